>>> rtl/bilinear_2x_upscaler_defines.svh
// ---------------------------------------------------------------------------
// bilinear_2x_upscaler_defines
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef BILINEAR_2X_UPSCALER_DEFINES_SVH
`define BILINEAR_2X_UPSCALER_DEFINES_SVH

// same-cycle implication
`define BU2X_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bu2x check failed");

// next-cycle implication
`define BU2X_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bu2x check failed");

`endif

>>> rtl/bu2x_pkg.sv
// ---------------------------------------------------------------------------
// bu2x_pkg
// shared types and constants of the bilinear 2x upscaler
// ---------------------------------------------------------------------------
package bu2x_pkg;

    localparam int MAX_SOURCE_WIDTH  = 1024;
    localparam int MAX_SOURCE_HEIGHT = 1024;

    localparam int PIX_W   = 24;
    localparam int CHAN_W  = 8;
    localparam int NUM_CH  = PIX_W / CHAN_W;
    localparam int COORD_W = 11;
    localparam int CFG_W   = 11;

    localparam int COL_W  = $clog2(MAX_SOURCE_WIDTH);
    localparam int ROW_W  = $clog2(MAX_SOURCE_HEIGHT);
    localparam int WCMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int HCMP_W = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

    localparam int IN_TDATA_W  = ((PIX_W + 7) / 8) * 8;
    localparam int OUT_RAW_W   = PIX_W + 2 * COORD_W;
    localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_RAW_W;
    localparam int OUT_X_LSB   = PIX_W;
    localparam int OUT_Y_LSB   = PIX_W + COORD_W;

    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_W-1:0] SOURCE_WIDTH_RST  = CFG_W'(320);
    localparam logic [CFG_W-1:0] SOURCE_HEIGHT_RST = CFG_W'(240);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SOURCE_WIDTH  = 1'b0,
        CFG_SOURCE_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef pix_t [3:0]         quad_t;

    // beat order within a block: top-left, top-right, bottom-left, bottom-right
    typedef logic [1:0] beat_t;
    localparam beat_t BEAT_FIRST = 2'd0;
    localparam beat_t BEAT_LAST  = 2'd3;

    typedef struct packed {
        logic first_row;
        logic first_col;
    } pos_t;

endpackage

>>> rtl/bu2x_line_store.sv
// ---------------------------------------------------------------------------
// bu2x_line_store
// one-row pixel store, synchronous read through a read data register
// ---------------------------------------------------------------------------
module bu2x_line_store (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [bu2x_pkg::COL_W-1:0] rd_addr,
    output bu2x_pkg::pix_t            rd_data,
    input  logic                      wr_en,
    input  logic [bu2x_pkg::COL_W-1:0] wr_addr,
    input  bu2x_pkg::pix_t            wr_data
);
    import bu2x_pkg::*;

    pix_t mem [MAX_SOURCE_WIDTH];
    pix_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/bu2x_blend.sv
// ---------------------------------------------------------------------------
// bu2x_blend
// per-channel truncating averages for one 2x2 output block
// ---------------------------------------------------------------------------
module bu2x_blend (
    input  bu2x_pkg::pix_t  cur,
    input  bu2x_pkg::pix_t  left,
    input  bu2x_pkg::pix_t  up,
    input  bu2x_pkg::pix_t  up_left,
    input  bu2x_pkg::pos_t  pos,
    output bu2x_pkg::quad_t quad
);
    import bu2x_pkg::*;

    pix_t avg_left;
    pix_t avg_up;
    pix_t avg_four;

    always_comb
    begin
        logic [CHAN_W:0]   sum2_l;
        logic [CHAN_W:0]   sum2_u;
        logic [CHAN_W+1:0] sum4;
        avg_left = '0;
        avg_up   = '0;
        avg_four = '0;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            sum2_l = {1'b0, cur[ch*CHAN_W +: CHAN_W]} + {1'b0, left[ch*CHAN_W +: CHAN_W]};
            sum2_u = {1'b0, cur[ch*CHAN_W +: CHAN_W]} + {1'b0, up[ch*CHAN_W +: CHAN_W]};
            sum4   = {1'b0, sum2_l} + {2'b00, up[ch*CHAN_W +: CHAN_W]}
                   + {2'b00, up_left[ch*CHAN_W +: CHAN_W]};
            avg_left[ch*CHAN_W +: CHAN_W] = sum2_l[CHAN_W:1];
            avg_up[ch*CHAN_W +: CHAN_W]   = sum2_u[CHAN_W:1];
            avg_four[ch*CHAN_W +: CHAN_W] = sum4[CHAN_W+1:2];
        end
    end

    always_comb
    begin
        quad[3] = cur;
        priority if (pos.first_row && pos.first_col)
        begin
            quad[0] = cur;
            quad[1] = cur;
            quad[2] = cur;
        end
        else if (pos.first_row)
        begin
            quad[0] = avg_left;
            quad[1] = cur;
            quad[2] = avg_left;
        end
        else if (pos.first_col)
        begin
            quad[0] = avg_up;
            quad[1] = avg_up;
            quad[2] = cur;
        end
        else
        begin
            quad[0] = avg_four;
            quad[1] = avg_up;
            quad[2] = avg_left;
        end
    end

endmodule

>>> rtl/bu2x_out_buf.sv
// ---------------------------------------------------------------------------
// bu2x_out_buf
// holds one finished 2x2 block and sends it as four beats
// ---------------------------------------------------------------------------
module bu2x_out_buf (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  bu2x_pkg::quad_t                  load_quad,
    input  bu2x_pkg::coord_t                 load_x,
    input  bu2x_pkg::coord_t                 load_y,
    output logic                             load_ready,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bu2x_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                             m_tlast
);
    import bu2x_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    beat_t  beat_reg;
    beat_t  beat_next;
    quad_t  quad_reg;
    coord_t x_reg;
    coord_t y_reg;
    logic   done;
    coord_t cur_x;
    coord_t cur_y;

    assign done       = valid_reg && m_tready && (beat_reg == BEAT_LAST);
    assign load_ready = !valid_reg || done;

    always_comb
    begin
        valid_next = valid_reg;
        beat_next  = beat_reg;
        if (load)
        begin
            valid_next = 1'b1;
            beat_next  = BEAT_FIRST;
        end
        else if (done)
        begin
            valid_next = 1'b0;
        end
        else if (valid_reg && m_tready)
        begin
            beat_next = beat_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            beat_reg  <= BEAT_FIRST;
        end
        else
        begin
            valid_reg <= valid_next;
            beat_reg  <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quad_reg <= load_quad;
            x_reg    <= load_x;
            y_reg    <= load_y;
        end
    end

    assign cur_x = x_reg | coord_t'(beat_reg[0]);
    assign cur_y = y_reg | coord_t'(beat_reg[1]);

    assign m_tvalid = valid_reg;
    assign m_tlast  = (beat_reg == BEAT_LAST);
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, cur_y, cur_x, quad_reg[beat_reg]};

endmodule

>>> rtl/bilinear_2x_upscaler.sv
// ---------------------------------------------------------------------------
// bilinear_2x_upscaler
// doubles a raster-order RGB stream in both directions by bilinear blending
// ---------------------------------------------------------------------------
// source pixels enter on s_tvalid/s_tready/s_tdata in raster order, one per
// beat. each one leaves as four beats on m_tvalid/m_tready/m_tdata/m_tlast in
// the order top-left, top-right, bottom-left, bottom-right; m_tlast marks the
// bottom-right beat. source_width and source_height are set through the
// cfg_we/cfg_addr/cfg_wdata port; the user must set them only while the
// block is idle, as the block itself does not enforce it. the first beat
// of a block leaves from the output buffer register, which is loaded from
// the combinational blend of the input stage and line store read registers.
// the next pixel is taken and its line store read started while the
// current block is still being sent.
// the previous row lives in a single-port-per-direction line store; a pixel
// read from the entry being written in the same cycle is forwarded.
// reset clears the counters, the neighbor registers and both channels; the
// line store is not cleared and needs no clearing pass.
// when m_tready is low the current beat holds, one more pixel waits in the
// input stage, and s_tready drops until the block is drained.
// ---------------------------------------------------------------------------
module bilinear_2x_upscaler (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [bu2x_pkg::IN_TDATA_W-1:0]       s_tdata,  // in_pixel
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [bu2x_pkg::OUT_TDATA_W-1:0]      m_tdata,  // out_pixel, out_x, out_y
    output logic                                  m_tlast,
    input  logic                                  cfg_we,
    input  logic [bu2x_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [bu2x_pkg::CFG_W-1:0]            cfg_wdata
);
    import bu2x_pkg::*;

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  width_next;
    logic [CFG_W-1:0]  height_reg;
    logic [CFG_W-1:0]  height_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    pix_t              s1_pixel_reg;
    logic [COL_W-1:0]  s1_col_reg;
    coord_t            s1_x_reg;
    coord_t            s1_y_reg;
    pos_t              s1_pos_reg;
    logic              s1_fwd_reg;
    pix_t              s1_fwd_pixel_reg;

    pix_t              left_reg;
    pix_t              up_left_reg;

    logic              accept;
    logic              commit;
    logic              load_ready;
    pix_t              rd_data;
    pix_t              up_pixel;
    quad_t             quad;
    logic [WCMP_W-1:0] eff_width;
    logic [WCMP_W-1:0] width_ext;
    logic [HCMP_W-1:0] eff_height;
    logic [HCMP_W-1:0] height_ext;
    logic              col_wrap;
    logic              row_wrap;

    assign accept   = s_tvalid && s_tready;
    assign commit   = s1_valid_reg && load_ready;
    assign s_tready = !s1_valid_reg || load_ready;

    // configuration
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_SOURCE_WIDTH:  width_next  = cfg_wdata;
                CFG_SOURCE_HEIGHT: height_next = cfg_wdata;
            endcase
        end
    end

    // frame position
    assign width_ext  = WCMP_W'(width_reg);
    assign height_ext = HCMP_W'(height_reg);

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_width = WCMP_W'(1);
        end
        else if (width_ext > WCMP_W'(MAX_SOURCE_WIDTH))
        begin
            eff_width = WCMP_W'(MAX_SOURCE_WIDTH);
        end
        else
        begin
            eff_width = width_ext;
        end

        if (height_reg == '0)
        begin
            eff_height = HCMP_W'(1);
        end
        else if (height_ext > HCMP_W'(MAX_SOURCE_HEIGHT))
        begin
            eff_height = HCMP_W'(MAX_SOURCE_HEIGHT);
        end
        else
        begin
            eff_height = height_ext;
        end
    end

    assign col_wrap = (WCMP_W'(col_reg) + WCMP_W'(1)) >= eff_width;
    assign row_wrap = (HCMP_W'(row_reg) + HCMP_W'(1)) >= eff_height;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    assign s1_valid_next = accept || (s1_valid_reg && !commit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= SOURCE_WIDTH_RST;
            height_reg   <= SOURCE_HEIGHT_RST;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            left_reg     <= '0;
            up_left_reg  <= '0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
            if (commit)
            begin
                left_reg    <= s1_pixel_reg;
                up_left_reg <= up_pixel;
            end
        end
    end

    // input stage, waits for the line store read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg     <= s_tdata[PIX_W-1:0];
            s1_col_reg       <= col_reg;
            s1_x_reg         <= coord_t'(col_reg) << 1;
            s1_y_reg         <= coord_t'(row_reg) << 1;
            s1_pos_reg       <= '{first_row: (row_reg == '0), first_col: (col_reg == '0)};
            s1_fwd_reg       <= commit && (s1_col_reg == col_reg);
            s1_fwd_pixel_reg <= s1_pixel_reg;
        end
    end

    bu2x_line_store u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (commit),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pixel_reg)
    );

    assign up_pixel = s1_fwd_reg ? s1_fwd_pixel_reg : rd_data;

    bu2x_blend u_blend (
        .cur     (s1_pixel_reg),
        .left    (left_reg),
        .up      (up_pixel),
        .up_left (up_left_reg),
        .pos     (s1_pos_reg),
        .quad    (quad)
    );

    bu2x_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (commit),
        .load_quad  (quad),
        .load_x     (s1_x_reg),
        .load_y     (s1_y_reg),
        .load_ready (load_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

>>> rtl/bu2x_checker.sv
// ---------------------------------------------------------------------------
// bu2x_checker
// port-level checks of the upscaler output stream
// ---------------------------------------------------------------------------
`include "bilinear_2x_upscaler_defines.svh"

module bu2x_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [bu2x_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tlast
);
    import bu2x_pkg::*;

    coord_t out_x;
    coord_t out_y;
    logic   stalled;
    logic   tl_taken;

    assign out_x    = m_tdata[OUT_X_LSB +: COORD_W];
    assign out_y    = m_tdata[OUT_Y_LSB +: COORD_W];
    assign stalled  = m_tvalid && !m_tready;
    assign tl_taken = m_tvalid && m_tready && !out_x[0] && !out_y[0];

    `BU2X_ASSERT_NEXT(a_stall_holds, stalled, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    `BU2X_ASSERT_SAME(a_last_odd, m_tvalid && m_tlast, m_tdata[OUT_X_LSB] && m_tdata[OUT_Y_LSB])

    `BU2X_ASSERT_NEXT(a_block_unbroken, m_tvalid && m_tready && !m_tlast, m_tvalid)

    `BU2X_ASSERT_NEXT(a_tl_then_tr, tl_taken, out_x[0] && !out_y[0] && $stable(out_y))

endmodule

bind bilinear_2x_upscaler bu2x_checker u_bu2x_checker (.*);
